[design/tlbkc_pkg.sv]
// Package for the two-list bitmap key cache.
// Holds the pool size, key and status types, and cell control codes.
// No dependencies.
package tlbkc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_TEMP   = 2'd1,
    ST_CACHED = 2'd2
  } entry_st_t;

  typedef enum logic [1:0] {
    RES_NOT_CACHED     = 2'd0,
    RES_CACHED_NOW     = 2'd1,
    RES_ALREADY_CACHED = 2'd2
  } res_st_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CM_HOLD      = 2'd0,
    CM_FROM_LOW  = 2'd1,
    CM_FROM_HIGH = 2'd2,
    CM_LOAD      = 2'd3
  } cell_mode_t;

  typedef struct packed {
    logic [63:0] digest;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  pixel_bytes;
  } key_t;

  typedef struct packed {
    key_t      key;
    entry_st_t st;
  } cell_data_t;

  typedef struct packed {
    logic       clear;
    cell_mode_t mode;
    entry_st_t  new_st;
  } cell_ctl_t;

  typedef struct packed {
    logic        opcode;
    logic [63:0] key_digest;
    logic [15:0] key_width;
    logic [15:0] key_height;
    logic [2:0]  key_pixel_bytes;
    logic        force_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        key_valid;
    logic        evicted;
    logic [63:0] evicted_digest;
    logic [15:0] evicted_width;
    logic [15:0] evicted_height;
    logic [2:0]  evicted_pixel_bytes;
  } out_beat_t;

endpackage

[design/tlbkc_in_if.sv]
// Valid/ready channel carrying lookup requests.
// Depends on tlbkc_pkg for the beat type.
interface tlbkc_in_if;
  logic                valid;
  logic                ready;
  tlbkc_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tlbkc_out_if.sv]
// Valid/ready channel carrying lookup results.
// Depends on tlbkc_pkg for the beat type.
interface tlbkc_out_if;
  logic                 valid;
  logic                 ready;
  tlbkc_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tlbkc_cell.sv]
// One slot of the recency row: holds a key and its status, compares it
// against the request and loads from a neighbor or the request key.
// Depends on tlbkc_pkg.
module tlbkc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlbkc_pkg::key_t       req_key,
  input  tlbkc_pkg::cell_ctl_t  ctl,
  input  tlbkc_pkg::cell_data_t low_nbr,
  input  tlbkc_pkg::cell_data_t high_nbr,
  output tlbkc_pkg::cell_data_t data,
  output logic                  match
);
  import tlbkc_pkg::*;

  key_t      key_r, key_nxt;
  entry_st_t st_r, st_nxt;

  always_comb begin
    key_nxt = key_r;
    st_nxt  = st_r;
    unique case (ctl.mode)
      CM_HOLD: begin
      end
      CM_FROM_LOW: begin
        key_nxt = low_nbr.key;
        st_nxt  = low_nbr.st;
      end
      CM_FROM_HIGH: begin
        key_nxt = high_nbr.key;
        st_nxt  = high_nbr.st;
      end
      CM_LOAD: begin
        key_nxt = req_key;
        st_nxt  = ctl.new_st;
      end
      default: begin
      end
    endcase
    if (ctl.clear) st_nxt = ST_EMPTY;
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) st_r <= ST_EMPTY;
    else        st_r <= st_nxt;
  end

  assign data.key = key_r;
  assign data.st  = st_r;
  assign match    = (st_r != ST_EMPTY) && (key_r == req_key);
endmodule

[design/two_list_bitmap_key_cache.sv]
// Two-list bitmap key cache: one request is taken at a time. Its result is
// registered as the update state ends: the compare state registers the
// match of the request against every slot, and the update state does the
// one-step shift of the slot row. The next request is taken in the cycle
// after that. A result still waiting on out ready holds back the row
// update, and with it the input.
// The slots form one row. The temporary list fills the low positions from
// most recent to oldest, and the cached list follows from oldest to most
// recent, so every move is a one-step shift.
// Depends on tlbkc_pkg, tlbkc_in_if, tlbkc_out_if and tlbkc_cell.
module two_list_bitmap_key_cache (
  input logic            clk,
  input logic            rst_n,
  tlbkc_in_if.sink       in_if,
  tlbkc_out_if.source    out_if
);
  import tlbkc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  in_beat_t               req_r;
  logic [ENTRIES-1:0]     match_r;
  logic [ENTRIES-1:0]     match_c;
  logic [ENTRIES-1:0]     cached_vec;
  logic [CNT_W-1:0]       nt_r, nt_nxt;
  logic                   oval_r, oval_nxt;
  out_beat_t              obeat_r, obeat_nxt;
  cell_data_t             cdata [ENTRIES];
  cell_ctl_t              cctl [ENTRIES];
  key_t                   req_key;
  logic                   do_upd, hit, hit_cached, go_left;
  logic [IDX_W-1:0]       hit_idx, pos;

  assign req_key = '{digest: req_r.key_digest, width: req_r.key_width,
                     height: req_r.key_height, pixel_bytes: req_r.key_pixel_bytes};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tlbkc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req_key  (req_key),
      .ctl      (cctl[i]),
      .low_nbr  (cdata[(i == 0) ? 0 : i - 1]),
      .high_nbr (cdata[(i == ENTRIES - 1) ? i : i + 1]),
      .data     (cdata[i]),
      .match    (match_c[i])
    );
    assign cached_vec[i] = (cdata[i].st == ST_CACHED);
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign do_upd      = (state_r == S_UPD) && (!oval_r || out_if.ready);

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) hit_idx = hit_idx | IDX_W'(i);
    end
  end

  assign hit        = |match_r;
  assign hit_cached = |(match_r & cached_vec);
  assign go_left    = hit || req_r.force_req;
  // The oldest temporary or empty slot sits at nt-1; with none left, the
  // oldest cached slot sits at position zero.
  assign pos = hit ? hit_idx : ((nt_r == '0) ? '0 : IDX_W'(nt_r - CNT_W'(1)));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cctl[i] = '{clear: 1'b0, mode: CM_HOLD, new_st: ST_TEMP};
      if (do_upd) begin
        if (req_r.opcode == OP_CLEAR) begin
          cctl[i].clear = 1'b1;
        end else if (req_r.key_pixel_bytes != 3'd0) begin
          if (go_left) begin
            cctl[i].new_st = ST_CACHED;
            if (i == ENTRIES - 1)         cctl[i].mode = CM_LOAD;
            else if (IDX_W'(i) >= pos)    cctl[i].mode = CM_FROM_HIGH;
          end else begin
            if (i == 0)                   cctl[i].mode = CM_LOAD;
            else if (IDX_W'(i) <= pos)    cctl[i].mode = CM_FROM_LOW;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    nt_nxt    = nt_r;
    oval_nxt  = oval_r;
    obeat_nxt = obeat_r;
    if (oval_r && out_if.ready) oval_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_if.valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_UPD;
      S_UPD: begin
        if (do_upd) begin
          state_nxt = S_IDLE;
          oval_nxt  = 1'b1;
          obeat_nxt = '0;
          if (req_r.opcode == OP_CLEAR) begin
            nt_nxt = CNT_W'(ENTRIES);
          end else if (req_r.key_pixel_bytes != 3'd0) begin
            obeat_nxt.key_valid = 1'b1;
            if (hit) begin
              obeat_nxt.status = hit_cached ? RES_ALREADY_CACHED : RES_CACHED_NOW;
              if (!hit_cached) nt_nxt = nt_r - CNT_W'(1);
            end else begin
              obeat_nxt.status = req_r.force_req ? RES_CACHED_NOW : RES_NOT_CACHED;
              if (nt_r == '0) begin
                obeat_nxt.evicted             = 1'b1;
                obeat_nxt.evicted_digest      = cdata[0].key.digest;
                obeat_nxt.evicted_width       = cdata[0].key.width;
                obeat_nxt.evicted_height      = cdata[0].key.height;
                obeat_nxt.evicted_pixel_bytes = cdata[0].key.pixel_bytes;
                if (!req_r.force_req) nt_nxt = CNT_W'(1);
              end else if (req_r.force_req) begin
                nt_nxt = nt_r - CNT_W'(1);
              end
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nt_r    <= CNT_W'(ENTRIES);
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nt_r    <= nt_nxt;
      oval_r  <= oval_nxt;
    end
    obeat_r <= obeat_nxt;
    if (in_if.valid && in_if.ready) req_r <= in_if.data;
    if (state_r == S_CMP) match_r <= match_c;
  end

  assign out_if.valid = oval_r;
  assign out_if.data  = obeat_r;
endmodule

[verif/two_list_bitmap_key_cache_test.sv]
// Self-checking testbench for the two-list bitmap key cache.
// It predicts each result from its own copy of the two recency lists.
// Depends on tlbkc_pkg, tlbkc_in_if, tlbkc_out_if and the cache RTL.
module two_list_bitmap_key_cache_test;
  import tlbkc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 550;
  localparam int POOL_SIZE      = 72;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlbkc_in_if  in_ch ();
  tlbkc_out_if out_ch ();

  two_list_bitmap_key_cache u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the cache: key and status per slot, each list kept head first.
  key_t      slot_key [ENTRIES];
  entry_st_t slot_st  [ENTRIES];
  int        temp_list [$];
  int        cached_list [$];

  in_beat_t  pending_requests [$];
  out_beat_t expected_results [$];
  key_t      key_pool [POOL_SIZE];

  int  error_count = 0;
  int  results_seen = 0;
  bit  quiet_phase = 1'b0;

  function automatic void clear_shadow();
    temp_list.delete();
    cached_list.delete();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_st[i] = ST_EMPTY;
      temp_list.push_back(i);
    end
  endfunction

  function automatic void drop_slot(ref int lst [$], input int idx);
    for (int i = 0; i < lst.size(); i++) begin
      if (lst[i] == idx) begin
        lst.delete(i);
        return;
      end
    end
  endfunction

  function automatic out_beat_t predict_lookup(in_beat_t req);
    out_beat_t res;
    key_t      k;
    int        hit;
    int        victim;
    res = '0;
    hit = -1;
    k.digest = req.key_digest;
    k.width = req.key_width;
    k.height = req.key_height;
    k.pixel_bytes = req.key_pixel_bytes;
    if (req.opcode == OP_CLEAR) begin
      clear_shadow();
      return res;
    end
    if (req.key_pixel_bytes == 3'd0) return res;
    res.key_valid = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_st[i] != ST_EMPTY && slot_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      if (slot_st[hit] == ST_CACHED) begin
        res.status = RES_ALREADY_CACHED;
        drop_slot(cached_list, hit);
      end else begin
        res.status = RES_CACHED_NOW;
        drop_slot(temp_list, hit);
        slot_st[hit] = ST_CACHED;
      end
      cached_list.push_front(hit);
      return res;
    end
    // A miss reuses the oldest empty or temporary slot, else evicts.
    if (temp_list.size() > 0) begin
      victim = temp_list.pop_back();
    end else begin
      victim = cached_list.pop_back();
    end
    if (slot_st[victim] == ST_CACHED) begin
      res.evicted = 1'b1;
      res.evicted_digest = slot_key[victim].digest;
      res.evicted_width = slot_key[victim].width;
      res.evicted_height = slot_key[victim].height;
      res.evicted_pixel_bytes = slot_key[victim].pixel_bytes;
    end
    slot_key[victim] = k;
    if (req.force_req) begin
      slot_st[victim] = ST_CACHED;
      cached_list.push_front(victim);
      res.status = RES_CACHED_NOW;
    end else begin
      slot_st[victim] = ST_TEMP;
      temp_list.push_front(victim);
      res.status = RES_NOT_CACHED;
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic in_beat_t make_req(logic op, key_t k, logic frc);
    in_beat_t r;
    r.opcode = op;
    r.key_digest = k.digest;
    r.key_width = k.width;
    r.key_height = k.height;
    r.key_pixel_bytes = k.pixel_bytes;
    r.force_req = frc;
    return r;
  endfunction

  function automatic key_t random_key(bit allow_zero_pb);
    key_t k;
    k.digest = {$urandom, $urandom};
    k.width = 16'($urandom);
    k.height = 16'($urandom);
    k.pixel_bytes = allow_zero_pb ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 7));
    return k;
  endfunction

  // Sender: holds a beat until it is taken, with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      clear_shadow();
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_results.push_back(predict_lookup(in_ch.data));
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        send_gap <= int'($urandom_range(0, 12));
        in_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_requests.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off to back up the input.
  int recv_stall = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with no expectation: actual %h", $time, out_ch.data);
          error_count++;
        end else begin
          out_beat_t exp_r;
          exp_r = expected_results.pop_front();
          check_field("status", 64'(exp_r.status), 64'(out_ch.data.status));
          check_field("key_valid", 64'(exp_r.key_valid), 64'(out_ch.data.key_valid));
          check_field("evicted", 64'(exp_r.evicted), 64'(out_ch.data.evicted));
          check_field("evicted_digest", exp_r.evicted_digest, out_ch.data.evicted_digest);
          check_field("evicted_width", 64'(exp_r.evicted_width),
                      64'(out_ch.data.evicted_width));
          check_field("evicted_height", 64'(exp_r.evicted_height),
                      64'(out_ch.data.evicted_height));
          check_field("evicted_pixel_bytes", 64'(exp_r.evicted_pixel_bytes),
                      64'(out_ch.data.evicted_pixel_bytes));
        end
        results_seen <= results_seen + 1;
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 120) begin
        long_hold_done <= 1'b1;
        recv_stall <= 300;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        recv_stall <= int'($urandom_range(0, 12));
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    key_t a;
    key_t b;
    key_t k;
    int   pick;
    a = random_key(1'b0);
    b = random_key(1'b0);
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key(1'b0);

    // Directed: clear, rejected keys, hits on both lists, extremes of fields.
    pending_requests.push_back(make_req(OP_CLEAR, random_key(1'b0), 1'b1));
    k = random_key(1'b0);
    k.pixel_bytes = 3'd0;
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b1));
    pending_requests.push_back(make_req(OP_LOOKUP, a, 1'b0));
    pending_requests.push_back(make_req(OP_LOOKUP, a, 1'b0));
    pending_requests.push_back(make_req(OP_LOOKUP, a, 1'b1));
    pending_requests.push_back(make_req(OP_LOOKUP, b, 1'b1));
    pending_requests.push_back(make_req(OP_LOOKUP, b, 1'b0));
    k = '{digest: '1, width: '1, height: '1, pixel_bytes: 3'd7};
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b0));
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b0));
    k = '{digest: '0, width: '0, height: '0, pixel_bytes: 3'd4};
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b1));
    k.pixel_bytes = 3'd5;
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b0));
    k.pixel_bytes = 3'd6;
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b1));
    k = '{digest: '1, width: '1, height: '1, pixel_bytes: 3'd0};
    pending_requests.push_back(make_req(OP_LOOKUP, k, 1'b1));
    pending_requests.push_back(make_req(OP_CLEAR, k, 1'b1));
    pending_requests.push_back(make_req(OP_LOOKUP, a, 1'b0));
    pending_requests.push_back(make_req(OP_LOOKUP, b, 1'b1));

    // Random: mostly a pool a bit larger than the cache, so hits and
    // evictions both occur; some fresh keys, rejects and rare clears.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 1) begin
        pending_requests.push_back(make_req(OP_CLEAR, random_key(1'b1), 1'($urandom)));
      end else if (pick < 6) begin
        k = random_key(1'b0);
        k.pixel_bytes = 3'd0;
        pending_requests.push_back(make_req(OP_LOOKUP, k, 1'($urandom)));
      end else if (pick < 11) begin
        pending_requests.push_back(make_req(OP_LOOKUP, random_key(1'b1), 1'($urandom)));
      end else begin
        pending_requests.push_back(make_req(OP_LOOKUP,
          key_pool[$urandom_range(0, POOL_SIZE - 1)], $urandom_range(0, 9) < 4));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_requests.size() < 100);
    quiet_phase = 1'b1;
    wait (pending_requests.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
